>>> rtl/core/assert_macros.svh
// assertion helpers for the core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/core/slwd_pkg.sv
`default_nettype none

package slwd_pkg;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int WORD_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int OUT_DATA_W  = WORD_W + 2 * COUNT_W;
    localparam int OUT_USER_W  = 1 + STATUS_W;

    localparam logic [BYTE_W-1:0]  SYNC_FIRST      = 8'hAA;
    localparam logic [BYTE_W-1:0]  SYNC_SECOND     = 8'h55;
    localparam logic [COUNT_W-1:0] MAX_WORDS_RESET = 16'd1250;

    typedef enum logic [STATUS_W-1:0] {
        ST_CONTINUE  = 2'd0,
        ST_COMPLETE  = 2'd1,
        ST_ABANDONED = 2'd2
    } t_status;

endpackage

`default_nettype wire

>>> rtl/core/sync_length_word_deframer_top.sv
// sync_length_word_deframer_top
// slave stream: one received byte per transfer on s_axis_tdata.
// the block hunts for the pair 0xAA 0x55, reads a little-endian 16-bit word
// count, then packs payload bytes little-endian into 32-bit words.
// master stream: one transfer per finished word, or one for an empty frame;
// tdata carries word, index and announced count, tuser the word flag and
// frame status (continue, complete, abandoned at the max_words limit).
// i_cfg_we / i_cfg_wdata write max_words; write only while the block is idle.
// an accepted byte passes the input register, then the result register, before
// its result shows on the master side.
// throughput: one byte per cycle while the master side does not stall, set by the
// combinational parse logic between the input register and the result register.
// when the master side stalls with a result held, a byte that yields no result
// still passes; a byte that yields one waits in the input register and
// s_axis_tready stays low until the held result is taken.
// reset (synchronous, active low) returns to the sync hunt, clears the word
// count and partial word, empties both registers and sets max_words to 1250.
`default_nettype none
`include "assert_macros.svh"

module sync_length_word_deframer_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [slwd_pkg::COUNT_W-1:0]   i_cfg_wdata,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] rx_byte
    input  wire [slwd_pkg::BYTE_W-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    // [31:0] payload_word, [47:32] word_index, [63:48] frame_length
    output logic [slwd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] word_valid, [2:1] frame_status
    output logic [slwd_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import slwd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_COUNT = 2'd2,
        PH_DATA  = 2'd3
    } t_phase;

    logic [COUNT_W-1:0] r_max_words;
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;

    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [1:0]         r_bpos, n_bpos;
    logic [23:0]        r_partial, n_partial;
    logic [COUNT_W-1:0] r_words, n_words;

    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_word;
    logic [COUNT_W-1:0] r_out_index;
    logic               r_out_wvalid;
    t_status            r_out_status;
    logic [COUNT_W-1:0] r_out_length;

    logic               emit;
    logic [WORD_W-1:0]  res_word;
    logic [COUNT_W-1:0] res_index;
    logic               res_wvalid;
    t_status            res_status;
    logic [COUNT_W-1:0] res_length;

    logic [COUNT_W-1:0] cnt_full;
    logic [COUNT_W-1:0] words_inc;
    logic [COUNT_W-1:0] limit;
    logic               out_free;
    logic               step;

    assign cnt_full  = {r_in_byte, r_count[7:0]};
    assign words_inc = r_words + COUNT_W'(1);
    assign limit     = (r_max_words == '0) ? COUNT_W'(1) : r_max_words;

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_bpos     = r_bpos;
        n_partial  = r_partial;
        n_words    = r_words;
        emit       = 1'b0;
        res_word   = '0;
        res_index  = '0;
        res_wvalid = 1'b0;
        res_status = ST_CONTINUE;
        res_length = '0;
        unique case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == SYNC_FIRST) begin
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (r_in_byte == SYNC_SECOND) begin
                    n_phase = PH_COUNT;
                    n_bpos  = 2'd0;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_COUNT: begin
                if (r_bpos == 2'd0) begin
                    n_count = {{(COUNT_W-BYTE_W){1'b0}}, r_in_byte};
                    n_bpos  = 2'd1;
                end else begin
                    n_count   = cnt_full;
                    n_bpos    = 2'd0;
                    n_partial = '0;
                    n_words   = '0;
                    if (cnt_full == '0) begin
                        // empty frame
                        n_phase    = PH_HUNT;
                        emit       = 1'b1;
                        res_status = ST_COMPLETE;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (r_bpos != 2'd3) begin
                    case (r_bpos)
                        2'd0:    n_partial[7:0]   = r_in_byte;
                        2'd1:    n_partial[15:8]  = r_in_byte;
                        default: n_partial[23:16] = r_in_byte;
                    endcase
                    n_bpos = r_bpos + 2'd1;
                end else begin
                    n_words    = words_inc;
                    n_bpos     = 2'd0;
                    n_partial  = '0;
                    emit       = 1'b1;
                    res_word   = {r_in_byte, r_partial};
                    res_index  = r_words;
                    res_wvalid = 1'b1;
                    res_length = r_count;
                    if (words_inc >= r_count) begin
                        res_status = ST_COMPLETE;
                        n_phase    = PH_HUNT;
                    end else if (words_inc >= limit) begin
                        res_status = ST_ABANDONED;
                        n_phase    = PH_HUNT;
                    end
                end
            end
            default: n_phase = PH_HUNT;
        endcase
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && (!emit || out_free);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_words <= MAX_WORDS_RESET;
            r_in_valid  <= 1'b0;
            r_phase     <= PH_HUNT;
            r_count     <= '0;
            r_bpos      <= 2'd0;
            r_partial   <= '0;
            r_words     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_words <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (step) begin
                r_phase   <= n_phase;
                r_count   <= n_count;
                r_bpos    <= n_bpos;
                r_partial <= n_partial;
                r_words   <= n_words;
            end
            if (step && emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (step && emit) begin
            r_out_word   <= res_word;
            r_out_index  <= res_index;
            r_out_wvalid <= res_wvalid;
            r_out_status <= res_status;
            r_out_length <= res_length;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_length, r_out_index, r_out_word};
    assign m_axis_tuser  = {r_out_status, r_out_wvalid};

    `ASSERT_NEVER(a_data_zero_count, i_clk, i_rst_n, (r_phase == PH_DATA) && (r_count == '0),
        "payload phase with zero word count")
    `ASSERT_CLK(a_empty_frame, i_clk, i_rst_n,
        (r_out_valid && !r_out_wvalid) |-> (r_out_status == ST_COMPLETE && r_out_length == '0),
        "empty-frame result with bad status or length")
    `ASSERT_CLK(a_complete_index, i_clk, i_rst_n,
        (r_out_valid && r_out_wvalid && r_out_status == ST_COMPLETE)
            |-> ((17'(r_out_index) + 17'd1) == 17'(r_out_length)),
        "complete word index does not match count")
    `ASSERT_CLK(a_abandon_index, i_clk, i_rst_n,
        (r_out_valid && r_out_status == ST_ABANDONED)
            |-> ((17'(r_out_index) + 17'd1) < 17'(r_out_length)),
        "abandoned frame already reached its count")

endmodule

`default_nettype wire
